// ----- src/command_line_tokenizer_macros.svh -----
// ----------------------------------------------------------------------------
// command line tokenizer assertion macros
// concurrent check wrappers, clocked on clk_i and held off during reset
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS

// plain property check
`define CLT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("command_line_tokenizer check failed");

// antecedent overlapping-implies consequent
`define CLT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("command_line_tokenizer implication failed");

// antecedent implies consequent in the next cycle
`define CLT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("command_line_tokenizer next-cycle check failed");

`else

`define CLT_ASSERT(lbl, prop)
`define CLT_ASSERT_IMP(lbl, ante, cons)
`define CLT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- src/clt_pkg.sv -----
// ----------------------------------------------------------------------------
// clt_pkg
// shared types and character codes of the command line tokenizer
// ----------------------------------------------------------------------------
package clt_pkg;

  // parser mode
  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_PLAIN   = 3'd1,
    MODE_QUOTED  = 3'd2,
    MODE_ESCAPED = 3'd3,
    MODE_CLOSED  = 3'd4,
    MODE_FAILED  = 3'd5
  } mode_e;

  // character codes
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChEscape = 8'h2A;
  localparam logic [7:0] ChEscOut = 8'h17;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChUpperE = 8'h45;
  localparam logic [7:0] ChUpperN = 8'h4E;

  // one result item
  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_value;
    logic       arg_start;
    logic       arg_end;
    logic [7:0] arg_number;
    logic       parse_error;
    logic       line_done;
    logic [8:0] total_args;
  } res_t;

  function automatic logic is_separator(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChNl);
  endfunction

endpackage

// ----- src/clt_step.sv -----
// ----------------------------------------------------------------------------
// clt_step
// per-byte parser decision: next mode, next argument count, result item
// ----------------------------------------------------------------------------
module clt_step #(
  parameter int MAX_ARGS = 256,
  parameter int CNT_W    = 13
) (
  input  clt_pkg::mode_e     mode_i,
  input  logic [CNT_W-1:0]   cnt_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  output clt_pkg::mode_e     mode_o,
  output logic [CNT_W-1:0]   cnt_o,
  output clt_pkg::res_t      res_o
);
  import clt_pkg::*;

  logic             sep;
  logic             cv;
  logic [7:0]       val;
  logic             start;
  logic             fin;
  logic             err;
  mode_e            mode_n;
  logic [CNT_W-1:0] cnt_n;
  logic [CNT_W-1:0] cnt_m1;

  assign sep = is_separator(byte_i);

  // mode transition and per-byte flags
  always_comb begin
    cv     = 1'b0;
    val    = 8'h00;
    start  = 1'b0;
    fin    = 1'b0;
    err    = 1'b0;
    mode_n = mode_i;
    cnt_n  = cnt_i;
    unique case (mode_i)
      MODE_PLAIN: begin
        if (sep) begin
          fin    = 1'b1;
          mode_n = MODE_BETWEEN;
        end else begin
          cv  = 1'b1;
          val = byte_i;
          fin = last_i;
        end
      end
      MODE_QUOTED: begin
        if (byte_i == ChQuote) begin
          fin    = 1'b1;
          mode_n = MODE_CLOSED;
        end else if (byte_i == ChEscape) begin
          mode_n = MODE_ESCAPED;
          err    = last_i;
        end else begin
          cv  = 1'b1;
          val = byte_i;
          err = last_i;
        end
      end
      MODE_ESCAPED: begin
        cv = 1'b1;
        if (byte_i == ChUpperE) begin
          val = ChEscOut;
        end else if (byte_i == ChUpperN) begin
          val = ChNl;
        end else begin
          val = byte_i;
        end
        mode_n = MODE_QUOTED;
        err    = last_i;
      end
      MODE_CLOSED: begin
        if (sep) begin
          mode_n = MODE_BETWEEN;
        end else begin
          err = 1'b1;
        end
      end
      MODE_FAILED: begin
        err = 1'b1;
      end
      default: begin
        // between arguments, also recovers from unused codes
        mode_n = MODE_BETWEEN;
        if (!sep && (cnt_i < CNT_W'(MAX_ARGS))) begin
          start = 1'b1;
          cnt_n = cnt_i + 1'b1;
          if (byte_i == ChQuote) begin
            mode_n = MODE_QUOTED;
            err    = last_i;
          end else begin
            cv     = 1'b1;
            val    = byte_i;
            mode_n = MODE_PLAIN;
            fin    = last_i;
          end
        end
      end
    endcase
    if (err) begin
      mode_n = MODE_FAILED;
    end
  end

  assign cnt_m1 = cnt_n - 1'b1;

  // result item, counts taken before the end-of-line reset
  always_comb begin
    res_o.char_valid  = cv;
    res_o.char_value  = val;
    res_o.arg_start   = start;
    res_o.arg_end     = fin;
    res_o.arg_number  = cnt_m1[7:0];
    res_o.parse_error = err;
    res_o.line_done   = last_i;
    res_o.total_args  = last_i ? cnt_n[8:0] : 9'd0;
  end

  // line end resets the parser
  assign mode_o = last_i ? MODE_BETWEEN : mode_n;
  assign cnt_o  = last_i ? CNT_W'(1) : cnt_n;

endmodule

// ----- src/command_line_tokenizer.sv -----
// latency: a result item is valid on the cycle after its byte is taken from the input register
// throughput: one byte per cycle unless stalled; sole loop: mode/count update in clt_step
// input register and result register decouple the two channels, ready is combinational
// from out_ready_i through both stages
// reset: asynchronous active low, parser between arguments with the count at one, stages empty
// ----------------------------------------------------------------------------
// command_line_tokenizer
// splits a byte stream into quoted or plain arguments, one result item per byte
// ----------------------------------------------------------------------------
`include "command_line_tokenizer_macros.svh"

module command_line_tokenizer #(
  parameter int MAX_ARGS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       char_valid_o,
  output logic [7:0] char_value_o,
  output logic       arg_start_o,
  output logic       arg_end_o,
  output logic [7:0] arg_number_o,
  output logic       parse_error_o,
  output logic       line_done_o,
  output logic [8:0] total_args_o
);
  import clt_pkg::*;

  localparam int CntBits = $clog2(MAX_ARGS + 1);
  localparam int CntW    = (CntBits > 9) ? CntBits : 9;

  logic            s1_valid_q;
  logic [7:0]      s1_byte_q;
  logic            s1_last_q;
  logic            out_valid_q;
  logic            out_valid_d;
  res_t            out_res_q;
  res_t            step_res;
  mode_e           mode_q;
  mode_e           mode_d;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;
  logic            adv;
  logic            in_acc;

  // handshake between the stages
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign out_valid_d = adv ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // parser decision for the held byte
  clt_step #(
    .MAX_ARGS (MAX_ARGS),
    .CNT_W    (CntW)
  ) u_step (
    .mode_i (mode_q),
    .cnt_i  (cnt_q),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .mode_o (mode_d),
    .cnt_o  (cnt_d),
    .res_o  (step_res)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_BETWEEN;
      cnt_q       <= CntW'(1);
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
      if (adv) begin
        mode_q <= mode_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  // input item register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // result item register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_valid_o  = out_res_q.char_valid;
  assign char_value_o  = out_res_q.char_value;
  assign arg_start_o   = out_res_q.arg_start;
  assign arg_end_o     = out_res_q.arg_end;
  assign arg_number_o  = out_res_q.arg_number;
  assign parse_error_o = out_res_q.parse_error;
  assign line_done_o   = out_res_q.line_done;
  assign total_args_o  = out_res_q.total_args;

  // checks
  `CLT_ASSERT_NXT(a_line_end_resets, adv && s1_last_q, (mode_q == MODE_BETWEEN) && (cnt_q == CntW'(1)))
  `CLT_ASSERT(a_count_in_range, (cnt_q != '0) && (cnt_q <= CntW'(MAX_ARGS)))
  `CLT_ASSERT_IMP(a_error_never_ends_arg, out_valid_q, !(out_res_q.parse_error && out_res_q.arg_end))
  `CLT_ASSERT_IMP(a_char_zero_when_idle, out_valid_q && !out_res_q.char_valid, out_res_q.char_value == 8'h00)

endmodule

// ----- test/command_line_tokenizer_test.sv -----
// ----------------------------------------------------------------------------
// command_line_tokenizer_test
// feeds command lines byte by byte, predicts every result item in a small
// scoreboard and compares all fields, under several idle and stall patterns
// ----------------------------------------------------------------------------
module command_line_tokenizer_test;
  import clt_pkg::*;

  localparam int ArgLimit    = 256;
  localparam int RandomItems = 950;

  // parser prediction and queue of expected result items
  class token_scoreboard;
    mode_e      mode;
    logic [8:0] arg_count;
    res_t       expected_q[$];
    int         failures;

    function new();
      failures = 0;
      clear_line();
    endfunction

    function void clear_line();
      mode      = MODE_BETWEEN;
      arg_count = 9'd1;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == ChSpace || c == ChTab || c == ChNl;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // work out the result of one accepted byte and queue it
    function void note_byte(logic [7:0] c, logic last);
      res_t r;
      r = '0;
      case (mode)
        MODE_PLAIN: begin
          if (is_blank(c)) begin
            r.arg_end = 1'b1;
            mode      = MODE_BETWEEN;
          end else begin
            r.char_valid = 1'b1;
            r.char_value = c;
            r.arg_end    = last;
          end
        end
        MODE_QUOTED: begin
          if (c == ChQuote) begin
            r.arg_end = 1'b1;
            mode      = MODE_CLOSED;
          end else if (c == ChEscape) begin
            mode          = MODE_ESCAPED;
            r.parse_error = last;
          end else begin
            r.char_valid  = 1'b1;
            r.char_value  = c;
            r.parse_error = last;
          end
        end
        MODE_ESCAPED: begin
          r.char_valid  = 1'b1;
          r.char_value  = (c == ChUpperE) ? ChEscOut : (c == ChUpperN) ? ChNl : c;
          mode          = MODE_QUOTED;
          r.parse_error = last;
        end
        MODE_CLOSED: begin
          if (is_blank(c)) mode = MODE_BETWEEN;
          else r.parse_error = 1'b1;
        end
        MODE_FAILED: begin
          r.parse_error = 1'b1;
        end
        default: begin
          mode = MODE_BETWEEN;
          if (!is_blank(c) && arg_count < ArgLimit) begin
            r.arg_start = 1'b1;
            arg_count++;
            if (c == ChQuote) begin
              mode          = MODE_QUOTED;
              r.parse_error = last;
            end else begin
              r.char_valid = 1'b1;
              r.char_value = c;
              mode         = MODE_PLAIN;
              r.arg_end    = last;
            end
          end
        end
      endcase
      if (r.parse_error) mode = MODE_FAILED;
      r.arg_number = arg_count[7:0] - 8'd1;
      r.line_done  = last;
      r.total_args = last ? arg_count : 9'd0;
      if (last) clear_line();
      expected_q.push_back(r);
    endfunction

    function void compare(string field, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%h, got 0x%h", field, want, got);
        failures++;
      end
    endfunction

    // compare one accepted result item against the oldest expectation
    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result item with no byte outstanding");
        failures++;
        return;
      end
      want = expected_q.pop_front();
      compare("char_valid", 9'(want.char_valid), 9'(got.char_valid));
      compare("char_value", 9'(want.char_value), 9'(got.char_value));
      compare("arg_start", 9'(want.arg_start), 9'(got.arg_start));
      compare("arg_end", 9'(want.arg_end), 9'(got.arg_end));
      compare("arg_number", 9'(want.arg_number), 9'(got.arg_number));
      compare("parse_error", 9'(want.parse_error), 9'(got.parse_error));
      compare("line_done", 9'(want.line_done), 9'(got.line_done));
      compare("total_args", want.total_args, got.total_args);
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i   = '0;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       char_valid_o;
  logic [7:0] char_value_o;
  logic       arg_start_o;
  logic       arg_end_o;
  logic [7:0] arg_number_o;
  logic       parse_error_o;
  logic       line_done_o;
  logic [8:0] total_args_o;
  res_t       out_item;

  int              send_idle_pct  = 0;
  int              recv_stall_pct = 0;
  int              sent_count     = 0;
  token_scoreboard sb;
  logic [7:0]      line_q[$];

  command_line_tokenizer #(
    .MAX_ARGS(ArgLimit)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .char_valid_o (char_valid_o),
    .char_value_o (char_value_o),
    .arg_start_o  (arg_start_o),
    .arg_end_o    (arg_end_o),
    .arg_number_o (arg_number_o),
    .parse_error_o(parse_error_o),
    .line_done_o  (line_done_o),
    .total_args_o (total_args_o)
  );

  assign out_item = {char_valid_o, char_value_o, arg_start_o, arg_end_o,
                     arg_number_o, parse_error_o, line_done_o, total_args_o};

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: check accepted items, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item);
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // present one byte and hold it until taken
  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_byte_i   <= c;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(c, last);
    sent_count++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    send_line();
  endtask

  // hold the sender off until every expected item is back
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(2))
      0: return ChSpace;
      1: return ChTab;
      default: return ChNl;
    endcase
  endfunction

  // byte that neither separates nor opens quotes
  function automatic logic [7:0] pick_word_byte();
    logic [7:0] c;
    do begin
      if ($urandom_range(3) == 0) c = 8'($urandom_range(255));
      else c = 8'($urandom_range(8'h7a, 8'h61));
    end while (sb.is_blank(c) || c == ChQuote);
    return c;
  endfunction

  // noise leaning on the bytes the parser cares about
  function automatic logic [7:0] pick_noise();
    case ($urandom_range(13))
      0: return ChQuote;
      1: return ChEscape;
      2: return ChSpace;
      3: return ChTab;
      4: return ChNl;
      5: return ChUpperE;
      6: return ChUpperN;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void add_plain();
    int n;
    n = $urandom_range(6, 1);
    line_q.push_back(pick_word_byte());
    for (int i = 1; i < n; i++)
      line_q.push_back(($urandom_range(9) == 0) ? ChQuote : pick_word_byte());
  endfunction

  // opening quote and content, closing quote left to the caller
  function automatic void add_quoted_body();
    int         n;
    logic [7:0] c;
    n = $urandom_range(6, 0);
    line_q.push_back(ChQuote);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0) begin
        line_q.push_back(ChEscape);
        case ($urandom_range(2))
          0: line_q.push_back(ChUpperE);
          1: line_q.push_back(ChUpperN);
          default: line_q.push_back(8'($urandom_range(255)));
        endcase
      end else if ($urandom_range(5) == 0) begin
        line_q.push_back(pick_sep());
      end else begin
        do c = 8'($urandom_range(255)); while (c == ChQuote || c == ChEscape);
        line_q.push_back(c);
      end
    end
  endfunction

  function automatic void add_args(int count);
    for (int a = 0; a < count; a++) begin
      if (a > 0 || $urandom_range(3) == 0)
        repeat ($urandom_range(3, 1)) line_q.push_back(pick_sep());
      if ($urandom_range(1)) begin
        add_plain();
      end else begin
        add_quoted_body();
        line_q.push_back(ChQuote);
      end
    end
  endfunction

  // well-formed, broken or noise line
  function automatic void build_line();
    int kind;
    kind = $urandom_range(99);
    if (kind < 70) begin
      add_args($urandom_range(5, 0));
      if ($urandom_range(2) == 0 || line_q.size() == 0) line_q.push_back(pick_sep());
    end else if (kind < 85) begin
      add_args($urandom_range(3, 0));
      if (line_q.size() > 0) line_q.push_back(pick_sep());
      add_quoted_body();
      case ($urandom_range(2))
        0: ;
        1: line_q.push_back(ChEscape);
        default: begin
          // non-separator after the closing quote, rest of the line is flagged as a parse error
          line_q.push_back(ChQuote);
          line_q.push_back(pick_word_byte());
          repeat ($urandom_range(4, 0)) line_q.push_back(pick_noise());
        end
      endcase
    end else begin
      repeat ($urandom_range(16, 1)) line_q.push_back(pick_noise());
    end
  endfunction

  // line that reaches the argument limit, then keeps going
  function automatic void build_full_line();
    for (int a = 1; a < ArgLimit - 1; a++) begin
      line_q.push_back(pick_word_byte());
      line_q.push_back(pick_sep());
    end
    add_quoted_body();
    line_q.push_back(ChQuote);
    if ($urandom_range(1)) line_q.push_back(pick_word_byte());
    else line_q.push_back(pick_sep());
    repeat (6) begin
      case ($urandom_range(2))
        0: line_q.push_back(pick_word_byte());
        1: line_q.push_back(ChQuote);
        default: line_q.push_back(pick_sep());
      endcase
    end
  endfunction

  // stimulus
  initial begin
    int line_no;
    int base;
    sb      = new();
    line_no = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines
    send_text("a");
    send_text("\"x");
    send_text("\"x*");
    send_text("\"*E*N*q\" ab");
    send_text("\"z\"ky");
    line_q = '{8'hff, ChTab, 8'h00, ChNl, 8'h80};
    send_line();
    wait_drained();

    // random lines, idle pattern changing every few lines
    base = sent_count;
    while (sent_count - base < RandomItems) begin
      case ((line_no / 6) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      if (line_no % 30 == 10) wait_drained();
      if (line_no == 20) build_full_line();
      else build_line();
      send_line();
      line_no++;
    end

    // drain and finish
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d result items never arrived", sb.pending());
      sb.failures++;
    end
    if (sb.failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
